// File: sv/mprs_pkg.sv
// Shared types and constants for the Merkle path root block.
package mprs_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD1,
      ST_RUN1,
      ST_LOAD2,
      ST_RUN2,
      ST_DONE
   } state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic subject;     // latch a subject transaction
      logic layer;       // latch a layer transaction
      logic load_blk1;   // set up first compression block
      logic load_blk2;   // set up padding block
      logic round;       // run one round
      logic finish_blk;  // add working vars into chaining state
      logic commit;      // write new cursor
      logic [5:0] rnd;   // round number
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic path_open;   // layers_done < layers_total
      logic last_layer;  // layers_done == layers_total after commit
   } sts_type;

   localparam logic [31:0] HINIT [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] KROUND [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
      32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
      32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
      32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
      32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
      32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
      32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
      32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
      32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [5:0] LAST_ROUND = 6'd63;

endpackage

// File: sv/mprs_if.sv
// Valid/ready channel interfaces for request and response transactions.
interface mprs_req_if;
   logic        valid;
   logic        ready;
   logic        is_subject;
   logic [5:0]  layer_count;
   logic [30:0] leaf_index;
   logic [30:0] tree_index;
   logic [63:0] hash_w0;
   logic [63:0] hash_w1;
   logic [63:0] hash_w2;
   logic [63:0] hash_w3;
   modport source (output valid, is_subject, layer_count, leaf_index, tree_index,
                   hash_w0, hash_w1, hash_w2, hash_w3, input ready);
   modport sink (input valid, is_subject, layer_count, leaf_index, tree_index,
                 hash_w0, hash_w1, hash_w2, hash_w3, output ready);
endinterface

interface mprs_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] root_hi;
   logic [63:0] root_lo;
   logic [5:0]  equal_layer;
   modport source (output valid, root_hi, root_lo, equal_layer, input ready);
   modport sink (input valid, root_hi, root_lo, equal_layer, output ready);
endinterface

// File: sv/mprs_ctrl.sv
// Sequencer: steps one layer through two 64-round compressions.
module mprs_ctrl
   import mprs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_fire,
   input  logic    req_subject,
   input  logic    zero_count,
   input  logic    rsp_taken,
   input  sts_type sts,
   output logic    busy,
   output logic    rsp_valid,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic [5:0] rnd_ff, rnd_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rnd_ff   <= '0;
      end else begin
         state_ff <= state_in;
         rnd_ff   <= rnd_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      rnd_in   = rnd_ff;
      cmd      = '0;
      cmd.rnd  = rnd_ff;
      busy     = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_DONE);
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_subject) begin
                  cmd.subject = 1'b1;
                  if (zero_count) state_in = ST_DONE;
               end else if (sts.path_open) begin
                  cmd.layer = 1'b1;
                  state_in  = ST_LOAD1;
               end
            end
         end
         ST_LOAD1: begin
            cmd.load_blk1 = 1'b1;
            rnd_in   = '0;
            state_in = ST_RUN1;
         end
         ST_RUN1: begin
            cmd.round = 1'b1;
            rnd_in    = rnd_ff + 6'd1;
            if (rnd_ff == LAST_ROUND) begin
               cmd.finish_blk = 1'b1;
               state_in = ST_LOAD2;
            end
         end
         ST_LOAD2: begin
            cmd.load_blk2 = 1'b1;
            rnd_in   = '0;
            state_in = ST_RUN2;
         end
         ST_RUN2: begin
            cmd.round = 1'b1;
            rnd_in    = rnd_ff + 6'd1;
            if (rnd_ff == LAST_ROUND) begin
               cmd.finish_blk = 1'b1;
               cmd.commit     = 1'b1;
               state_in = sts.last_layer ? ST_DONE : ST_IDLE;
            end
         end
         ST_DONE: begin
            if (rsp_taken) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// File: sv/mprs_dp.sv
// Datapath: path state, message schedule, SHA-256 round logic.
module mprs_dp
   import mprs_pkg::*;
#(
   parameter int MAX_LAYERS = 40
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  logic [5:0]  layer_count,
   input  logic [30:0] leaf_index,
   input  logic        tree_bit,
   input  logic [255:0] hash_in,
   output sts_type     sts,
   output logic [63:0] root_hi,
   output logic [63:0] root_lo,
   output logic [5:0]  equal_layer
);

   logic [255:0] cursor_ff, cursor_in;
   logic [255:0] sib_ff;
   logic [31:0]  side_ff, side_in;
   logic         tbit_ff, tbit_in;
   logic [5:0]   total_ff, total_in;
   logic [5:0]   done_ff, done_in;
   logic         eqs_ff, eqs_in;
   logic [5:0]   eqp_ff, eqp_in;
   logic         bit_ff;
   logic [31:0]  w_ff [16];
   logic [31:0]  h_ff [8];
   logic [31:0]  v_ff [8];

   logic [5:0]   cnt_sat;
   logic [5:0]   next_done;
   logic         side_bit;
   logic [511:0] blk1;
   logic [31:0]  s0, s1, wnew, t1, t2;

   always_comb begin
      cnt_sat = (layer_count > 6'(MAX_LAYERS)) ? 6'(MAX_LAYERS) : layer_count;
      next_done = done_ff + 6'd1;
      if (next_done == total_ff)                side_bit = 1'b1;
      else if (done_ff + 6'd2 == total_ff)      side_bit = tbit_ff;
      else                                      side_bit = side_ff[0];
      blk1 = bit_ff ? {sib_ff, cursor_ff} : {cursor_ff, sib_ff};
      s0 = {w_ff[1][6:0], w_ff[1][31:7]} ^ {w_ff[1][17:0], w_ff[1][31:18]}
           ^ (w_ff[1] >> 3);
      s1 = {w_ff[14][16:0], w_ff[14][31:17]} ^ {w_ff[14][18:0], w_ff[14][31:19]}
           ^ (w_ff[14] >> 10);
      wnew = w_ff[0] + s0 + w_ff[9] + s1;
      t1 = v_ff[7] + ({v_ff[4][5:0], v_ff[4][31:6]} ^ {v_ff[4][10:0], v_ff[4][31:11]}
           ^ {v_ff[4][24:0], v_ff[4][31:25]}) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
           + KROUND[cmd.rnd] + w_ff[0];
      t2 = ({v_ff[0][1:0], v_ff[0][31:2]} ^ {v_ff[0][12:0], v_ff[0][31:13]}
           ^ {v_ff[0][21:0], v_ff[0][31:22]})
           + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   always_comb begin
      cursor_in = cursor_ff;
      side_in = side_ff;
      tbit_in = tbit_ff;
      total_in = total_ff;
      done_in = done_ff;
      eqs_in = eqs_ff;
      eqp_in = eqp_ff;
      if (cmd.subject) begin
         cursor_in = hash_in;
         side_in   = {1'b0, leaf_index};
         tbit_in   = tree_bit;
         total_in  = cnt_sat;
         done_in   = '0;
         eqs_in    = 1'b0;
         eqp_in    = '0;
      end else if (cmd.layer) begin
         if (!eqs_ff && cursor_ff == hash_in) begin
            eqs_in = 1'b1;
            eqp_in = done_ff;
         end
      end else if (cmd.commit) begin
         for (int i = 0; i < 8; i++)
            cursor_in[255-32*i -: 32] = h_ff[i] + ((i == 0) ? t1 + t2 :
                                         (i == 4) ? v_ff[3] + t1 : v_ff[3'(i - 1)]);
         side_in = side_ff >> 1;
         done_in = next_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         side_ff   <= '0;
         tbit_ff   <= 1'b0;
         total_ff  <= '0;
         done_ff   <= '0;
         eqs_ff    <= 1'b0;
         eqp_ff    <= '0;
      end else begin
         cursor_ff <= cursor_in;
         side_ff   <= side_in;
         tbit_ff   <= tbit_in;
         total_ff  <= total_in;
         done_ff   <= done_in;
         eqs_ff    <= eqs_in;
         eqp_ff    <= eqp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.layer) begin
         sib_ff <= hash_in;
         bit_ff <= side_bit;
      end
      if (cmd.load_blk1) begin
         for (int i = 0; i < 16; i++) w_ff[i] <= blk1[511-32*i -: 32];
         for (int i = 0; i < 8; i++) begin
            h_ff[i] <= HINIT[i];
            v_ff[i] <= HINIT[i];
         end
      end else if (cmd.load_blk2) begin
         for (int i = 0; i < 16; i++)
            w_ff[i] <= (i == 0) ? 32'h80000000 : (i == 15) ? 32'd512 : 32'd0;
         for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
      end else if (cmd.round) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= wnew;
         v_ff[0] <= t1 + t2;
         v_ff[1] <= v_ff[0];
         v_ff[2] <= v_ff[1];
         v_ff[3] <= v_ff[2];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[5] <= v_ff[4];
         v_ff[6] <= v_ff[5];
         v_ff[7] <= v_ff[6];
         if (cmd.finish_blk) begin
            h_ff[0] <= h_ff[0] + t1 + t2;
            h_ff[1] <= h_ff[1] + v_ff[0];
            h_ff[2] <= h_ff[2] + v_ff[1];
            h_ff[3] <= h_ff[3] + v_ff[2];
            h_ff[4] <= h_ff[4] + v_ff[3] + t1;
            h_ff[5] <= h_ff[5] + v_ff[4];
            h_ff[6] <= h_ff[6] + v_ff[5];
            h_ff[7] <= h_ff[7] + v_ff[6];
         end
      end
   end

   assign sts.path_open  = (done_ff < total_ff);
   assign sts.last_layer = (next_done == total_ff);
   assign root_hi     = cursor_ff[255:192];
   assign root_lo     = cursor_ff[191:128];
   assign equal_layer = eqs_ff ? eqp_ff : total_ff;

endmodule

// File: sv/merkle_path_root_sha256_top.sv
// Top level of the Merkle path root folder.
// A subject transaction opens a path (layer count saturates at MAX_LAYERS); each
// layer transaction hashes the cursor with one sibling via two SHA-256
// compressions on one shared round unit, one round per cycle. After a layer is
// accepted, the block loads the first block, runs 64 rounds, loads the padding
// block and runs 64 rounds before it is ready again. The block handles one
// transaction at a time; after the final layer, or a subject with zero layers,
// the result is held on rsp until taken, and req is not ready meanwhile.
// Stray layers with no open path are accepted and dropped.
module merkle_path_root_sha256_top
   import mprs_pkg::*;
#(
   parameter int MAX_LAYERS = 40
) (
   input  logic      clock,
   input  logic      reset,
   mprs_req_if.sink   req,
   mprs_rsp_if.source rsp
);

   cmd_type cmd;
   sts_type sts;
   logic    busy;
   logic    req_fire;

   assign req.ready = !busy;
   assign req_fire  = req.valid && req.ready;

   mprs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_fire    (req_fire),
      .req_subject (req.is_subject),
      .zero_count  (req.layer_count == 6'd0),
      .rsp_taken   (rsp.ready),
      .sts         (sts),
      .busy        (busy),
      .rsp_valid   (rsp.valid),
      .cmd         (cmd)
   );

   mprs_dp #(.MAX_LAYERS(MAX_LAYERS)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .layer_count (req.layer_count),
      .leaf_index  (req.leaf_index),
      .tree_bit    (req.tree_index[0]),
      .hash_in     ({req.hash_w0, req.hash_w1, req.hash_w2, req.hash_w3}),
      .sts         (sts),
      .root_hi     (rsp.root_hi),
      .root_lo     (rsp.root_lo),
      .equal_layer (rsp.equal_layer)
   );

   // No new transaction while a result waits.
   a_no_accept_when_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready) else $error("req ready while rsp pending");

   // A response is never issued mid-compression.
   a_rsp_after_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> $past(cmd.commit) || $past(cmd.subject))
      else $error("response without commit or subject");

   // Equal layer never exceeds configured maximum.
   a_eq_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.equal_layer <= 6'(MAX_LAYERS))
      else $error("equal_layer out of range");

endmodule

// File: tb/mprs_checker.sv
// Checker: watches both channels, predicts root results and compares them.
module mprs_checker
   import mprs_pkg::*;
#(
   parameter int MAX_LAYERS = 40
) (
   input  logic      clock,
   input  logic      reset,
   mprs_req_if       req,
   mprs_rsp_if       rsp,
   output int        fail_count,
   output int        pending_roots
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [63:0] root_hi;
      logic [63:0] root_lo;
      logic [5:0]  equal_layer;
   } root_type;

   root_type    root_queue[$];
   logic [63:0] cursor [4];
   logic [31:0] side_idx;
   logic        tree_bit;
   logic [5:0]  total_layers;
   logic [5:0]  done_layers;
   logic        eq_seen;
   logic [5:0]  eq_pos;

   function automatic logic [31:0] rotr(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic void sha_block(ref logic [31:0] st[8], input logic [31:0] blk[16]);
      logic [31:0] w[64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      for (int i = 0; i < 16; i++) w[i] = blk[i];
      for (int i = 16; i < 64; i++) begin
         s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      a = st[0]; b = st[1]; c = st[2]; d = st[3];
      e = st[4]; f = st[5]; g = st[6]; h = st[7];
      for (int i = 0; i < 64; i++) begin
         t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
              + KROUND[i] + w[i];
         t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      st[0] += a; st[1] += b; st[2] += c; st[3] += d;
      st[4] += e; st[5] += f; st[6] += g; st[7] += h;
   endfunction

   // new cursor = SHA-256(lft || rgt)
   function automatic void hash_node(input logic [63:0] lft[4], input logic [63:0] rgt[4],
                                     output logic [63:0] node[4]);
      logic [31:0] st[8];
      logic [31:0] blk[16];
      for (int i = 0; i < 8; i++) st[i] = HINIT[i];
      for (int i = 0; i < 4; i++) begin
         blk[2*i]   = lft[i][63:32];
         blk[2*i+1] = lft[i][31:0];
         blk[8+2*i]   = rgt[i][63:32];
         blk[8+2*i+1] = rgt[i][31:0];
      end
      sha_block(st, blk);
      for (int i = 0; i < 16; i++) blk[i] = '0;
      blk[0]  = 32'h80000000;
      blk[15] = 32'd512;
      sha_block(st, blk);
      for (int i = 0; i < 4; i++) node[i] = {st[2*i], st[2*i+1]};
   endfunction

   task automatic fold_transaction();
      logic [63:0] sib[4];
      logic [5:0]  cnt;
      logic        bit_left;
      root_type    r;
      sib = '{req.hash_w0, req.hash_w1, req.hash_w2, req.hash_w3};
      if (req.is_subject) begin
         cnt = (req.layer_count > MAX_LAYERS) ? 6'(MAX_LAYERS) : req.layer_count;
         cursor = sib;
         side_idx = {1'b0, req.leaf_index};
         tree_bit = req.tree_index[0];
         total_layers = cnt;
         done_layers = 0;
         eq_seen = 0;
         eq_pos = 0;
         if (cnt == 0) begin
            r = '{cursor[0], cursor[1], 6'd0};
            root_queue.push_back(r);
         end
      end else if (done_layers < total_layers) begin
         if (done_layers + 1 == total_layers) bit_left = 1'b1;
         else if (done_layers + 2 == total_layers) bit_left = tree_bit;
         else bit_left = side_idx[0];
         if (!eq_seen && cursor == sib) begin
            eq_seen = 1;
            eq_pos = done_layers;
         end
         if (bit_left) hash_node(sib, cursor, cursor);
         else hash_node(cursor, sib, cursor);
         side_idx >>= 1;
         done_layers++;
         if (done_layers == total_layers) begin
            r = '{cursor[0], cursor[1], eq_seen ? eq_pos : total_layers};
            root_queue.push_back(r);
         end
      end
   endtask

   assign pending_roots = root_queue.size();

   always @(posedge clock) begin
      root_type exp_root;
      if (reset) begin
         root_queue.delete();
         cursor = '{default: '0};
         side_idx = 0; tree_bit = 0; total_layers = 0; done_layers = 0;
         eq_seen = 0; eq_pos = 0;
         fail_count = 0;
      end else begin
         // response first: a result can't be caused by the same-edge request
         if (rsp.valid && rsp.ready) begin
            if (root_queue.size() == 0) begin
               $error("unexpected result transaction");
               fail_count++;
            end else begin
               exp_root = root_queue.pop_front();
               if (rsp.root_hi !== exp_root.root_hi) begin
                  $error("root_hi exp %h got %h", exp_root.root_hi, rsp.root_hi);
                  fail_count++;
               end
               if (rsp.root_lo !== exp_root.root_lo) begin
                  $error("root_lo exp %h got %h", exp_root.root_lo, rsp.root_lo);
                  fail_count++;
               end
               if (rsp.equal_layer !== exp_root.equal_layer) begin
                  $error("equal_layer exp %0d got %0d", exp_root.equal_layer,
                         rsp.equal_layer);
                  fail_count++;
               end
            end
         end
         if (req.valid && req.ready) fold_transaction();
      end
   end
endmodule

// File: tb/tb.sv
// Testbench top: stimulus, response backpressure and final verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mprs_pkg::*;

   logic clock = 0;
   logic reset = 1;
   int   fail_count;
   int   pending_roots;
   bit   calm;          // last part of run: no idling on either side

   mprs_req_if req ();
   mprs_rsp_if rsp ();

   merkle_path_root_sha256_top dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));
   mprs_checker chk (.clock(clock), .reset(reset), .req(req), .rsp(rsp),
                     .fail_count(fail_count), .pending_roots(pending_roots));

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // Watchdog. Worst case ~900 layers plus stalls is well under this.
   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end

   // Response side: random stall bursts, none once calm.
   initial begin
      rsp.ready = 0;
      forever begin
         @(negedge clock);
         if (calm || $urandom_range(0, 3) != 0) begin
            rsp.ready <= 1;
            repeat ($urandom_range(1, 20)) @(negedge clock);
         end else begin
            rsp.ready <= 0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
      end
   end

   // Drive one transaction, hold valid until accepted. Called at a negedge;
   // returns at the negedge after the accepting edge with valid still high.
   task automatic send_txn(bit subj, logic [5:0] cnt, logic [30:0] leaf,
                           logic [30:0] tree, logic [63:0] h0, logic [63:0] h1,
                           logic [63:0] h2, logic [63:0] h3);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req.valid <= 0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req.valid <= 1;
      req.is_subject <= subj;
      req.layer_count <= cnt;
      req.leaf_index <= leaf;
      req.tree_index <= tree;
      req.hash_w0 <= h0; req.hash_w1 <= h1; req.hash_w2 <= h2; req.hash_w3 <= h3;
      // ready only moves at the rising edge, so it is stable here
      while (!req.ready) @(negedge clock);
      @(negedge clock);
   endtask

   function automatic logic [63:0] rnd64();
      return {$urandom, $urandom};
   endfunction

   task automatic send_layer_rnd();
      send_txn(0, 6'($urandom), 31'($urandom), 31'($urandom),
               rnd64(), rnd64(), rnd64(), rnd64());
   endtask

   // Well-formed path: subject then cnt layers; the first sibling may equal the leaf.
   task automatic send_path(logic [5:0] cnt, bit dup_first);
      logic [63:0] h0, h1, h2, h3;
      h0 = rnd64(); h1 = rnd64(); h2 = rnd64(); h3 = rnd64();
      send_txn(1, cnt, 31'($urandom), 31'($urandom), h0, h1, h2, h3);
      for (int i = 0; i < cnt; i++) begin
         if (i == 0 && dup_first)
            send_txn(0, 6'($urandom), 31'($urandom), 31'($urandom), h0, h1, h2, h3);
         else send_layer_rnd();
      end
   endtask

   initial begin
      int sent;
      int n;
      req.valid = 0; req.is_subject = 0; req.layer_count = 0;
      req.leaf_index = 0; req.tree_index = 0;
      req.hash_w0 = 0; req.hash_w1 = 0; req.hash_w2 = 0; req.hash_w3 = 0;
      calm = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: stray layer after reset, empty path, extremes of fields.
      send_layer_rnd();
      send_txn(1, 0, '1, '1, '1, '1, '1, '1);
      send_txn(1, 0, 0, 0, 0, 0, 0, 0);
      send_txn(1, 2, '1, '1, 0, 0, 0, 0);            // leaf=0 -> equal at layer 0
      send_txn(0, 0, 0, 0, 0, 0, 0, 0);
      send_txn(0, '1, '1, '1, '1, '1, '1, '1);
      send_layer_rnd();                              // stray after path end
      send_txn(1, 63, 0, 0, '1, '1, '1, '1);         // count saturates
      for (int i = 0; i < 3; i++) send_layer_rnd();
      send_path(3, 0);                               // restart abandons open path
      send_txn(1, 1, 31'h2aaaaaaa, 31'h55555555, rnd64(), rnd64(), rnd64(), rnd64());
      send_layer_rnd();
      sent = 20;

      // Pause until every outstanding root has drained.
      req.valid <= 0;
      wait (pending_roots == 0);
      @(negedge clock);

      // Random part: mostly short well-formed paths, a few long, some noise.
      while (sent < 900) begin
         if (sent > 780) calm = 1;
         case ($urandom_range(0, 19))
            0: begin send_layer_rnd(); sent++; end
            1: begin
               send_txn(1, 6'($urandom), 31'($urandom), 31'($urandom),
                        rnd64(), rnd64(), rnd64(), rnd64());
               sent++;
            end
            2: begin
               n = $urandom_range(1, 4);               // well-formed path of n + 3 layers
               send_path(6'(n + 3), 0);
               sent += n + 4;
            end
            3: begin
               send_path(6'($urandom_range(30, 40)), 1'($urandom_range(0, 1)));
               sent += 41;
            end
            default: begin
               n = $urandom_range(0, 6);
               send_path(6'(n), $urandom_range(0, 3) == 0);
               sent += n + 1;
            end
         endcase
      end

      req.valid <= 0;
      wait (pending_roots == 0);
      repeat (200) @(posedge clock);
      if (fail_count == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end
endmodule
